// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants and types for the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int DEPTH    = 31;
   localparam int KEY_BITS = 10;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CHILD_W  = ADDR_W + 1;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   typedef enum logic {
      FUNC_PUSH   = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Access to the heap memory for one cycle: one write, two reads.
   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [KEY_BITS-1:0] wr_data;
      logic [ADDR_W-1:0]   rd_addr_a;
      logic [ADDR_W-1:0]   rd_addr_b;
   } mem_req_type;

   typedef struct packed {
      logic [CNT_W-1:0]    count;
      logic                top_valid;
      logic [KEY_BITS-1:0] top_key;
      status_type          status;
   } res_type;

endpackage

// ===== rtl/mhpq_mem.sv =====
// ----------------------------------------------------------------------------
// mhpq_mem
// Heap key store: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mhpq_mem (
   input  logic                          clock,
   input  mhpq_pkg::mem_req_type         mem_req,
   output logic [mhpq_pkg::KEY_BITS-1:0] rd_data_a,
   output logic [mhpq_pkg::KEY_BITS-1:0] rd_data_b
);

   logic [mhpq_pkg::KEY_BITS-1:0] heap_mem_ff [mhpq_pkg::DEPTH];
   logic [mhpq_pkg::KEY_BITS-1:0] rd_data_a_ff;
   logic [mhpq_pkg::KEY_BITS-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         heap_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_a_ff <= heap_mem_ff[mem_req.rd_addr_a];
      rd_data_b_ff <= heap_mem_ff[mem_req.rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for push and remove: walks the heap one level per cycle.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  mhpq_pkg::func_type              cmd_func,
   input  logic [mhpq_pkg::KEY_BITS-1:0]   cmd_key,
   input  logic [mhpq_pkg::ADDR_W-1:0]     cmd_pos,
   output mhpq_pkg::mem_req_type           mem_req,
   input  logic [mhpq_pkg::KEY_BITS-1:0]   rd_data_a,
   input  logic [mhpq_pkg::KEY_BITS-1:0]   rd_data_b,
   output logic                            idle,
   output logic                            done,
   input  logic                            res_ready,
   output mhpq_pkg::res_type               res
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_UP_CMP  = 8'b0000_0010,
      S_SH_CMP  = 8'b0000_0100,
      S_LAST_RD = 8'b0000_1000,
      S_LAST    = 8'b0001_0000,
      S_DN_CMP  = 8'b0010_0000,
      S_PUT     = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [mhpq_pkg::ADDR_W-1:0]    idx_ff, idx_in;
   logic [mhpq_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [mhpq_pkg::KEY_BITS-1:0]  carry_ff, carry_in;
   mhpq_pkg::status_type           status_ff, status_in;
   logic [mhpq_pkg::KEY_BITS-1:0]  root_ff;

   logic [mhpq_pkg::ADDR_W-1:0]    par;
   logic [mhpq_pkg::CHILD_W-1:0]   left_c;
   logic [mhpq_pkg::CHILD_W-1:0]   right_c;
   logic                           take_l;
   logic                           take_r;
   logic [mhpq_pkg::KEY_BITS-1:0]  best_l;

   function automatic logic [mhpq_pkg::ADDR_W-1:0] parent_of(
      input logic [mhpq_pkg::ADDR_W-1:0] i
   );
      logic [mhpq_pkg::ADDR_W-1:0] d;
      d = i - mhpq_pkg::ADDR_W'(1);
      return d >> 1;
   endfunction

   // Address of a child, or slot zero when that child is outside the heap.
   function automatic logic [mhpq_pkg::ADDR_W-1:0] child_addr(
      input logic [mhpq_pkg::ADDR_W-1:0] i,
      input logic                        right,
      input logic [mhpq_pkg::CNT_W-1:0]  n
   );
      logic [mhpq_pkg::CHILD_W-1:0] c;
      c = {i, 1'b0} + (right ? mhpq_pkg::CHILD_W'(2) : mhpq_pkg::CHILD_W'(1));
      return (c < mhpq_pkg::CHILD_W'(n)) ? c[mhpq_pkg::ADDR_W-1:0] : '0;
   endfunction

   assign par     = parent_of(idx_ff);
   assign left_c  = {idx_ff, 1'b1};
   assign right_c = {idx_ff, 1'b0} + mhpq_pkg::CHILD_W'(2);

   // Larger child wins only when strictly larger; the left one wins a tie.
   assign take_l = (left_c < mhpq_pkg::CHILD_W'(cnt_ff)) && (rd_data_a > carry_ff);
   assign best_l = take_l ? rd_data_a : carry_ff;
   assign take_r = (right_c < mhpq_pkg::CHILD_W'(cnt_ff)) && (rd_data_b > best_l);

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      cnt_in            = cnt_ff;
      carry_in          = carry_ff;
      status_in         = status_ff;
      mem_req.wr_en     = 1'b0;
      mem_req.wr_addr   = idx_ff;
      mem_req.wr_data   = carry_ff;
      mem_req.rd_addr_a = '0;
      mem_req.rd_addr_b = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = mhpq_pkg::ST_DONE;
               if (cmd_func == mhpq_pkg::FUNC_PUSH) begin
                  if (cnt_ff == mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH)) begin
                     status_in = mhpq_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     idx_in   = cnt_ff[mhpq_pkg::ADDR_W-1:0];
                     carry_in = cmd_key;
                     cnt_in   = cnt_ff + mhpq_pkg::CNT_W'(1);
                     if (cnt_ff == '0) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = '0;
                        mem_req.wr_data = cmd_key;
                        state_in        = S_DONE;
                     end else begin
                        mem_req.rd_addr_a = parent_of(cnt_ff[mhpq_pkg::ADDR_W-1:0]);
                        state_in          = S_UP_CMP;
                     end
                  end
               end else begin
                  if (mhpq_pkg::CNT_W'(cmd_pos) >= cnt_ff) begin
                     status_in = mhpq_pkg::ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     idx_in = cmd_pos;
                     if (cmd_pos == '0) begin
                        state_in = S_LAST_RD;
                     end else begin
                        mem_req.rd_addr_a = parent_of(cmd_pos);
                        state_in          = S_SH_CMP;
                     end
                  end
               end
            end
         end

         S_UP_CMP: begin
            // The new key rides in carry_ff; the hole moves up past smaller parents.
            mem_req.wr_en = 1'b1;
            if (carry_ff > rd_data_a) begin
               mem_req.wr_data = rd_data_a;
               idx_in          = par;
               if (par == '0) begin
                  state_in = S_PUT;
               end else begin
                  mem_req.rd_addr_a = parent_of(par);
               end
            end else begin
               state_in = S_DONE;
            end
         end

         S_SH_CMP: begin
            // Each ancestor on the path moves down one level.
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = rd_data_a;
            idx_in          = par;
            if (par == '0) begin
               state_in = S_LAST_RD;
            end else begin
               mem_req.rd_addr_a = parent_of(par);
            end
         end

         S_LAST_RD: begin
            mem_req.rd_addr_a = mhpq_pkg::ADDR_W'(cnt_ff - mhpq_pkg::CNT_W'(1));
            cnt_in            = cnt_ff - mhpq_pkg::CNT_W'(1);
            idx_in            = '0;
            state_in          = S_LAST;
         end

         S_LAST: begin
            carry_in          = rd_data_a;
            mem_req.rd_addr_a = child_addr('0, 1'b0, cnt_ff);
            mem_req.rd_addr_b = child_addr('0, 1'b1, cnt_ff);
            state_in          = S_DN_CMP;
         end

         S_DN_CMP: begin
            mem_req.wr_en = 1'b1;
            if (take_r) begin
               mem_req.wr_data   = rd_data_b;
               idx_in            = right_c[mhpq_pkg::ADDR_W-1:0];
               mem_req.rd_addr_a = child_addr(right_c[mhpq_pkg::ADDR_W-1:0], 1'b0, cnt_ff);
               mem_req.rd_addr_b = child_addr(right_c[mhpq_pkg::ADDR_W-1:0], 1'b1, cnt_ff);
            end else if (take_l) begin
               mem_req.wr_data   = rd_data_a;
               idx_in            = left_c[mhpq_pkg::ADDR_W-1:0];
               mem_req.rd_addr_a = child_addr(left_c[mhpq_pkg::ADDR_W-1:0], 1'b0, cnt_ff);
               mem_req.rd_addr_b = child_addr(left_c[mhpq_pkg::ADDR_W-1:0], 1'b1, cnt_ff);
            end else begin
               state_in = S_DONE;
            end
         end

         S_PUT: begin
            mem_req.wr_en = 1'b1;
            state_in      = S_DONE;
         end

         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      carry_ff  <= carry_in;
      status_ff <= status_in;
      if (mem_req.wr_en && (mem_req.wr_addr == '0)) begin
         root_ff <= mem_req.wr_data;
      end
   end

   assign idle          = (state_ff == S_IDLE);
   assign done          = (state_ff == S_DONE);
   assign res.status    = status_ff;
   assign res.count     = cnt_ff;
   assign res.top_valid = (cnt_ff != '0);
   assign res.top_key   = (cnt_ff != '0) ? root_ff : '0;

endmodule

// ===== rtl/max_heap_priority_queue_top.sv =====
// A push climbs the heap level by level; a remove shifts the path down level
// by level and then sifts the new root down. Each level waits on the registered
// read of the key memory. One transaction at a time: a new request is taken
// only once the previous one is done.
// Reset (synchronous, active high) empties the heap; stored keys are not cleared.
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top
// Binary max-heap priority queue with stream request and response channels.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // key_in [9:0], position [14:10], zero [15]
   input  logic        req_tuser,  // func: 0 push, 1 remove
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // status [1:0], top_key [11:2], top_valid [12],
                                   // count [17:13], zero [23:18]
);

   mhpq_pkg::mem_req_type          mem_req;
   logic [mhpq_pkg::KEY_BITS-1:0]  rd_data_a;
   logic [mhpq_pkg::KEY_BITS-1:0]  rd_data_b;
   logic                           ctrl_idle;
   logic                           ctrl_done;
   logic                           res_ready;
   mhpq_pkg::res_type              res;
   mhpq_pkg::func_type             cmd_func;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mhpq_pkg::RSP_DATA_W-1:0]      rsp_data_ff;

   // A request transaction is taken whenever the sequencer is idle.
   assign req_tready = ctrl_idle;
   assign cmd_func   = mhpq_pkg::func_type'(req_tuser);

   // The response register frees up when empty or when its transaction completes,
   // so the sequencer may finish while the previous response is being taken.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && ctrl_idle),
      .cmd_func  (cmd_func),
      .cmd_key   (req_tdata[9:0]),
      .cmd_pos   (req_tdata[14:10]),
      .mem_req   (mem_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .idle      (ctrl_idle),
      .done      (ctrl_done),
      .res_ready (res_ready),
      .res       (res)
   );

   mhpq_mem u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl_done && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result fields packed from the lowest bit up, padded to whole bytes.
   always_ff @(posedge clock) begin
      if (ctrl_done && res_ready) begin
         rsp_data_ff <= mhpq_pkg::RSP_DATA_W'(res);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/max_heap_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top_tb
// Self-checking bench for the binary max-heap priority queue. A heap tracker
// keeps its own copy of the key array and entry count, predicts the response
// to every accepted request and compares it field by field with the block.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top_tb;

   import mhpq_pkg::*;

   // This limit leaves a wide margin over roughly 1100 requests, even with
   // both sides stalling.
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned RANDOM_ITEMS = 1100;
   localparam int unsigned IDLE_PCT     = 16;

   // Keeps a shadow of the heap, works out the expected response of every
   // accepted request and checks the responses in order.
   class heap_tracker;
      bit [KEY_BITS-1:0] slots [DEPTH];
      int unsigned       held;
      res_type           expected_results [$];
      int unsigned       failures;
      int unsigned       pushes;
      int unsigned       removes;
      int unsigned       full_refusals;
      int unsigned       range_refusals;

      function void swap_slots(int unsigned a, int unsigned b);
         bit [KEY_BITS-1:0] t;
         t        = slots[a];
         slots[a] = slots[b];
         slots[b] = t;
      endfunction

      function void note_request(func_type op, bit [KEY_BITS-1:0] key, bit [4:0] pos);
         res_type     r;
         int unsigned i;
         int unsigned p;
         int unsigned l;
         int unsigned rt;
         int unsigned big;
         r        = '0;
         r.status = ST_DONE;
         if (op == FUNC_PUSH) begin
            pushes++;
            if (held >= DEPTH) begin
               r.status = ST_FULL;
               full_refusals++;
            end else begin
               // Append at the end and climb while strictly larger than the parent.
               slots[held] = key;
               i = held;
               held++;
               while (i > 0) begin
                  p = (i - 1) / 2;
                  if (slots[i] > slots[p]) begin
                     swap_slots(i, p);
                     i = p;
                  end else begin
                     break;
                  end
               end
            end
         end else begin
            removes++;
            if (pos >= held) begin
               r.status = ST_RANGE;
               range_refusals++;
            end else begin
               // Ancestors on the path move down a level, emptying the root.
               i = pos;
               while (i > 0) begin
                  p = (i - 1) / 2;
                  slots[i] = slots[p];
                  i = p;
               end
               slots[0] = slots[held - 1];
               held--;
               // Sift the new root down; the left child wins a tie.
               i = 0;
               while (i < held) begin
                  l   = 2 * i + 1;
                  rt  = 2 * i + 2;
                  big = i;
                  if (l < held && slots[big] < slots[l]) begin
                     big = l;
                  end
                  if (rt < held && slots[big] < slots[rt]) begin
                     big = rt;
                  end
                  if (big == i) begin
                     break;
                  end
                  swap_slots(i, big);
                  i = big;
               end
            end
         end
         r.top_valid = (held > 0);
         r.top_key   = (held > 0) ? slots[0] : '0;
         r.count     = held[CNT_W-1:0];
         expected_results = {expected_results, r};
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         res_type got;
         res_type want;
         got = res_type'(data[$bits(res_type)-1:0]);
         if (expected_results.size() == 0) begin
            $error("response arrived with no request outstanding");
            failures++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("top_key", 32'(want.top_key), 32'(got.top_key));
         compare_field("top_valid", 32'(want.top_valid), 32'(got.top_valid));
         compare_field("count", 32'(want.count), 32'(got.count));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // key_in [9:0], position [14:10], zero [15]
   logic                  req_tuser;   // func: 0 push, 1 remove
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // status [1:0], top_key [11:2], top_valid [12],
                                       // count [17:13], zero [23:18]

   heap_tracker  tracker = new;
   bit           idling_on = 1'b1;
   int unsigned  cycle_count = 0;
   int unsigned  stim_count = 0;       // keys held, as the stimulus side sees it

   max_heap_priority_queue_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Both channels are observed at the rising edge, where a transaction takes
   // place. The request is noted first so that the order holds even if a
   // response could ever come in the same cycle as its request.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         tracker.note_request(func_type'(req_tuser), req_tdata[9:0], req_tdata[14:10]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_response(rsp_tdata);
      end
   end

   // The receiver stalls at random while idling is on, and holds ready low during reset.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idling_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   // Offers one request and returns once the block has taken it. The valid
   // line is left high, so back-to-back requests keep it up unless the sender idles.
   task automatic send_request(func_type op, bit [KEY_BITS-1:0] key, bit [4:0] pos);
      @(negedge clock);
      while (idling_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, pos, key};
      do @(posedge clock); while (!req_tready);
   endtask

   // Withdraws the request line first, so the last request is not offered a
   // second time once the block is idle again, then waits for every response.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Extremes of key and position, removes on an empty heap, removal of the
   // root and of the last slot, out-of-range positions and equal keys. The
   // sequence empties the heap again at its end.
   task automatic run_directed();
      send_request(FUNC_REMOVE, 10'd0, 5'd0);
      send_request(FUNC_REMOVE, 10'd0, 5'd31);
      send_request(FUNC_PUSH, 10'd1023, 5'd0);
      send_request(FUNC_PUSH, 10'd0, 5'd31);
      send_request(FUNC_PUSH, 10'd0, 5'd0);
      send_request(FUNC_PUSH, 10'd1023, 5'd31);
      send_request(FUNC_PUSH, 10'd341, 5'd10);
      send_request(FUNC_PUSH, 10'd682, 5'd21);
      send_request(FUNC_REMOVE, 10'd1023, 5'd5);
      send_request(FUNC_REMOVE, 10'd0, 5'd0);
      send_request(FUNC_REMOVE, 10'd0, 5'd3);
      send_request(FUNC_REMOVE, 10'd0, 5'd4);
      send_request(FUNC_REMOVE, 10'd0, 5'd21);
      send_request(FUNC_PUSH, 10'd1, 5'd0);
      send_request(FUNC_REMOVE, 10'd0, 5'd2);
      send_request(FUNC_REMOVE, 10'd0, 5'd1);
      send_request(FUNC_REMOVE, 10'd0, 5'd0);
      send_request(FUNC_REMOVE, 10'd0, 5'd0);
      send_request(FUNC_REMOVE, 10'd1023, 5'd0);
   endtask

   // Random part in phases: first a fill past the capacity, then a drain past
   // empty, then alternating push-heavy, remove-heavy and balanced phases.
   // Most removes name a held slot; one in ten, or all when empty, is out of range.
   task automatic run_random(int unsigned total);
      int unsigned       n;
      int unsigned       push_pct;
      func_type          op;
      bit [KEY_BITS-1:0] key;
      bit [4:0]          pos;
      for (n = 0; n < total; n++) begin
         if (n < 40) begin
            push_pct = 100;
         end else if (n < 80) begin
            push_pct = 0;
         end else begin
            case (((n - 80) / 50) % 3)
               0:       push_pct = 80;
               1:       push_pct = 20;
               default: push_pct = 50;
            endcase
         end
         // A long stretch with both sides always ready.
         idling_on = !(n >= 600 && n < 800);
         // Once in the run the sender holds off until the block has answered
         // everything it has taken.
         if (n == total / 2) begin
            wait_for_results();
         end
         case ($urandom_range(7))
            0:       key = '0;
            1:       key = '1;
            2:       key = KEY_BITS'($urandom_range(3));
            default: key = KEY_BITS'($urandom_range(1023));
         endcase
         pos = 5'($urandom_range(31));
         if ($urandom_range(99) < push_pct) begin
            op = FUNC_PUSH;
            if (stim_count < DEPTH) begin
               stim_count++;
            end
         end else begin
            op = FUNC_REMOVE;
            if (stim_count > 0 && $urandom_range(9) != 0) begin
               case ($urandom_range(3))
                  0:       pos = 5'd0;
                  1:       pos = 5'(stim_count - 1);
                  default: pos = 5'($urandom_range(stim_count - 1, 0));
               endcase
               stim_count--;
            end else begin
               pos = 5'($urandom_range(31, stim_count));
            end
         end
         send_request(op, key, pos);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_PUSH;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(RANDOM_ITEMS);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_for_results();
      // Let a stray response show up if the block produced one too many.
      repeat (20) @(posedge clock);

      $display("Covered %0d pushes and %0d removes; %0d pushes met a full heap, %0d removes",
               tracker.pushes, tracker.removes, tracker.full_refusals,
               tracker.range_refusals);
      $display("named an empty slot; one drained pause and a stall-free stretch included.");
      if (tracker.failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
